/* rtl/fifo_with_delete_by_value_macros.svh */
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef FIFO_WITH_DELETE_BY_VALUE_MACROS_SVH
`define FIFO_WITH_DELETE_BY_VALUE_MACROS_SVH

// Same-cycle implication.
`define FWDV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FWDV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fwdv_pkg.sv */
package fwdv_pkg;

  localparam int FRONT_W = 32;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic    done;
    status_e status;
  } ctrl_res_t;

endpackage

/* rtl/fwdv_req_if.sv */
interface fwdv_req_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

/* rtl/fwdv_rsp_if.sv */
interface fwdv_rsp_if import fwdv_pkg::*; #(
  parameter int CNT_W = 5
) ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FRONT_W-1:0] front_value;
  logic [CNT_W-1:0]   entry_count;
  logic               is_empty;

  modport source (output valid, output status, output front_value, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input front_value, input entry_count,
                  input is_empty, output ready);
endinterface

/* rtl/fwdv_ram.sv */
module fwdv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fwdv_ctrl.sv */
module fwdv_ctrl import fwdv_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int AW         = $clog2(DEPTH),
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  action_e                req_action_i,
  input  logic [VALUE_WIDTH-1:0] req_value_i,
  output logic                   req_ready_o,
  input  logic                   out_free_i,
  output ctrl_res_t              res_o,
  output logic [VALUE_WIDTH-1:0] front_o,
  output logic [CW-1:0]          count_o,
  output logic                   ram_we_o,
  output logic [AW-1:0]          ram_waddr_o,
  output logic [VALUE_WIDTH-1:0] ram_wdata_o,
  output logic                   ram_re_o,
  output logic [AW-1:0]          ram_raddr_o,
  input  logic [VALUE_WIDTH-1:0] ram_rdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_CAP   = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  status_e                status_q, status_d;
  logic                   byp_q, byp_d;

  // physical slot of a queue offset
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    val_d       = val_q;
    status_d    = status_q;
    byp_d       = byp_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = slot(head_q, idx_q - CW'(1));
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = slot(head_q, idx_q);
    res_o       = '{done: 1'b0, status: status_q};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          val_d    = req_value_i;
          byp_d    = 1'b0;
          status_d = ST_OK;
          state_d  = S_CAP;
          unique case (req_action_i)
            ACT_PUSH: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = head_q;
              if (cnt_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = slot(head_q, cnt_q);
                ram_wdata_o = req_value_i;
                cnt_d       = cnt_q + CW'(1);
                byp_d       = (cnt_q == '0);
              end
            end
            ACT_POP: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                head_d      = slot(head_q, CW'(1));
                cnt_d       = cnt_q - CW'(1);
                ram_re_o    = 1'b1;
                ram_raddr_o = slot(head_q, CW'(1));
              end
            end
            ACT_DELETE: begin
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = head_q;
                idx_d       = CW'(1);
                state_d     = S_SCAN;
              end
            end
            ACT_QUERY: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = head_q;
            end
          endcase
        end
      end
      // read data holds offset idx_q-1
      S_SCAN: begin
        if (ram_rdata_i == val_q) begin
          if (idx_q < cnt_q) begin
            ram_re_o = 1'b1;
            state_d  = S_SHIFT;
          end else begin
            cnt_d   = cnt_q - CW'(1);
            state_d = S_FRONT;
          end
        end else if (idx_q < cnt_q) begin
          ram_re_o = 1'b1;
          idx_d    = idx_q + CW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = S_FRONT;
        end
      end
      // read data holds offset idx_q, moved down one place
      S_SHIFT: begin
        ram_we_o = 1'b1;
        if ((idx_q + CW'(1)) < cnt_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = slot(head_q, idx_q + CW'(1));
          idx_d       = idx_q + CW'(1);
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_FRONT;
        end
      end
      S_FRONT: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = head_q;
        state_d     = S_CAP;
      end
      S_CAP: begin
        if (out_free_i) begin
          res_o.done = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign count_o     = cnt_q;
  assign front_o     = (cnt_q == '0) ? '0 : (byp_q ? val_q : ram_rdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      status_q <= ST_OK;
      byp_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      status_q <= status_d;
      byp_q    <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* rtl/fifo_with_delete_by_value.sv */
// Bounded FIFO of data handles with removal of the first matching entry.
// req_i carries a request (action, value): push, pop front, delete first
// match, or query. rsp_o returns one response per request: status, the
// front entry after the request (zero when empty), entry count and empty flag.
// Both channels move a request or response when valid and ready are high.
// Push, pop and query go from acceptance straight to the capture state.
// Delete: a walk through the entry RAM, one read a cycle, then one shift a
// cycle for each entry past the match. The entry RAM has a single read
// port. A new request is taken only once the previous response is
// captured and the sequencer is back in idle.
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls and a second response is ready, the
// block holds it and takes no further request until the register frees.
// Reset clears head, count and sequencer; the queue comes up empty and RAM
// contents are left as they are. entry_count holds a $clog2(DEPTH+1)-bit count.
module fifo_with_delete_by_value import fwdv_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fwdv_req_if.sink   req_i,
  fwdv_rsp_if.source rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ctrl_res_t              res;
  logic [VALUE_WIDTH-1:0] front;
  logic [CW-1:0]          count;
  logic                   out_free;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [63:0]            front_ext;

  logic                   rsp_valid_q;
  status_e                rsp_status_q;
  logic [FRONT_W-1:0]     rsp_front_q;
  logic [CW-1:0]          rsp_count_q;

  fwdv_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (action_e'(req_i.action)),
    .req_value_i  (req_i.value),
    .req_ready_o  (req_i.ready),
    .out_free_i   (out_free),
    .res_o        (res),
    .front_o      (front),
    .count_o      (count),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  fwdv_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign front_ext = 64'(front);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res.done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      rsp_status_q <= res.status;
      rsp_front_q  <= front_ext[FRONT_W-1:0];
      rsp_count_q  <= count;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.front_value = rsp_front_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.is_empty    = (rsp_count_q == '0);

`include "fifo_with_delete_by_value_macros.svh"

  `FWDV_ASSERT_IMP(a_full_count, rsp_valid_q && rsp_status_q == ST_FULL,
                   rsp_count_q == CW'(DEPTH), "full status with free room")
  `FWDV_ASSERT_IMP(a_empty_count, rsp_valid_q && rsp_status_q == ST_EMPTY,
                   rsp_count_q == '0, "empty status with stored entries")
  `FWDV_ASSERT_NXT(a_busy_after_req, req_i.valid && req_i.ready,
                   !req_i.ready, "request taken while previous one in flight")
  `FWDV_ASSERT_NXT(a_done_lands, res.done, rsp_valid_q && rsp_count_q <= CW'(DEPTH),
                   "response lost or count out of range")

endmodule
